>>> rtl/core/sliding_window_kmer_complexity_defines.svh
// assertion macros for the k-mer complexity block
`ifndef SLIDING_WINDOW_KMER_COMPLEXITY_DEFINES_SVH
`define SLIDING_WINDOW_KMER_COMPLEXITY_DEFINES_SVH
`ifndef SYNTHESIS
`define SWK_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
`define SWK_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define SWK_ASSERT(lbl, clk, rst_n, prop)
`define SWK_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

>>> rtl/core/swkc_pkg.sv
// shared constants, types and functions of the k-mer complexity block
`timescale 1ns / 1ps
package swkc_pkg;
    localparam int DEF_MAX_WINDOW = 21;
    localparam int DEF_MAX_KMER = 10;
    localparam int BITS_PER_SYMBOL = 3;
    localparam int KSET_BITS = 9;
    localparam int Q_ONE = 65536;
    localparam logic [4:0] WSIZE_RESET = 5'd21;
    localparam logic [8:0] KSET_RESET = 9'd511;
    localparam logic CFG_WSIZE = 1'b0;
    localparam logic CFG_KSET = 1'b1;

    typedef logic [2:0] t_sym;

    function automatic t_sym sym_code(input logic [7:0] c);
        t_sym r;
        case (c)
            8'h41, 8'h61: r = 3'd0;
            8'h43, 8'h63: r = 3'd1;
            8'h47, 8'h67: r = 3'd2;
            8'h54, 8'h74: r = 3'd3;
            default:      r = 3'd4;
        endcase
        return r;
    endfunction
endpackage

>>> rtl/core/swkc_div.sv
// radix-2 restoring divider for the q16 ratio (count << 16) / limit
`timescale 1ns / 1ps
module swkc_div import swkc_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [5:0]  i_num,
    input  logic [5:0]  i_den,
    output logic        o_done,
    output logic [22:0] o_quo
);
    logic [22:0] r_dvd;
    logic [6:0]  r_rem;
    logic [5:0]  r_den;
    logic [4:0]  r_cnt;
    logic        r_busy;
    logic [6:0]  w_trial;
    logic        w_ge;

    assign w_trial = {r_rem[5:0], r_dvd[22]};
    assign w_ge = w_trial >= {1'b0, r_den};
    assign o_quo = r_dvd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt <= '0;
        end else begin
            o_done <= !i_start && r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt <= 5'd23;
                r_dvd <= {1'b0, i_num, 16'd0};
                r_rem <= '0;
                r_den <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? (w_trial - {1'b0, r_den}) : w_trial;
                r_dvd <= {r_dvd[21:0], w_ge};
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) r_busy <= 1'b0;
            end
        end
    end
endmodule

>>> rtl/core/sliding_window_kmer_complexity.sv
// sliding window k-mer complexity: a handshaked item port, a config port, a stream of results.
// s_axis carries one character and an end flag; m_axis carries the Q1.16 complexity.
// After an item is accepted the block drops s_axis_tready while it works.
// Each enabled k from 2 to 10 compares its n = W-k+1 k-mers pairwise on the single
// code comparator, then runs the shared serial divider, a product step and a k-select
// step; a disabled k passes only the k-select step.
// Items that give no result (window still filling) do not leave the idle state.
// The comparator and serial divider set how long an item takes.
// Results are emitted one per cycle from a one-deep output register; a stalled
// m_axis_tready holds that register and the sequencer waits.
// Each result item carries tlast on the last result of its request.
// Reset (synchronous, active low) empties the window and loads window_size 21, k_set 511.
// A config write also empties the window; write only while idle.
// No clearing pass: entries are always written before they are read.
`timescale 1ns / 1ps
`include "sliding_window_kmer_complexity_defines.svh"
module sliding_window_kmer_complexity import swkc_pkg::*; #(
    parameter int MAX_WINDOW = DEF_MAX_WINDOW,
    parameter int MAX_KMER = DEF_MAX_KMER
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,    // symbol[7:0]
    input  logic        s_axis_tlast,    // end_of_stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,    // complexity[16:0], zero fill
    output logic        m_axis_tlast,    // last_of_run
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [8:0]  i_cfg_data
);
    localparam int WB = $clog2(MAX_WINDOW + 1);
    localparam int SB = $clog2(MAX_WINDOW);
    localparam int CW = MAX_KMER * BITS_PER_SYMBOL;

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_KSEL = 3'd1;
    localparam logic [2:0] ST_CMP  = 3'd2;
    localparam logic [2:0] ST_DIV  = 3'd3;
    localparam logic [2:0] ST_MUL  = 3'd4;
    localparam logic [2:0] ST_EMIT = 3'd5;

    logic [2:0]    r_state;
    logic [4:0]    r_wsize;
    logic [8:0]    r_kset;
    logic [WB-1:0] r_seen;
    logic [SB-1:0] r_slot;
    t_sym          r_syms [MAX_WINDOW];
    logic [3:0]    r_n;
    logic [WB-1:0] r_i, r_j;
    logic          r_dup;
    logic [5:0]    r_cnt;
    logic [5:0]    r_lim;
    logic [16:0]   r_prod;
    logic [16:0]   r_cplx;
    logic [5:0]    r_copies;
    logic          r_ovf;
    logic          r_dstart;
    logic          w_ddone;
    logic [22:0]   w_quo;

    logic [WB-1:0] w_w;
    logic [WB-1:0] w_k;
    logic [WB-1:0] w_nk;
    logic [CW-1:0] w_ci, w_cj;
    logic [5:0]    w_cap;

    always_comb begin
        logic [4:0] t;
        t = r_wsize;
        if (t < 5'd5) t = 5'd5;
        if (32'(t) > MAX_WINDOW) t = 5'(MAX_WINDOW);
        if (!t[0]) t = t - 5'd1;
        w_w = WB'(t);
    end

    assign w_k = WB'(r_n) + WB'(2);
    assign w_nk = w_w - w_k + WB'(1);

    // k-mer codes built from the symbol ring, oldest first
    function automatic logic [CW-1:0] kcode(input logic [WB-1:0] pos, input logic [WB-1:0] k,
                                            input logic [WB-1:0] w, input logic [SB-1:0] slot,
                                            input t_sym syms [MAX_WINDOW]);
        logic [CW-1:0] c;
        logic [WB+1:0] idx;
        c = '0;
        for (int t = 0; t < MAX_KMER; t++) begin
            idx = (WB+2)'(slot) + (WB+2)'(MAX_WINDOW) - (WB+2)'(w) + (WB+2)'(pos) + (WB+2)'(t);
            if (idx >= (WB+2)'(MAX_WINDOW)) idx = idx - (WB+2)'(MAX_WINDOW);
            if (idx >= (WB+2)'(MAX_WINDOW)) idx = idx - (WB+2)'(MAX_WINDOW);
            if ((WB)'(t) < k) c = {c[CW-BITS_PER_SYMBOL-1:0], syms[idx[SB-1:0]]};
        end
        return c;
    endfunction

    assign w_ci = kcode(r_i, w_k, w_w, r_slot, r_syms);
    assign w_cj = kcode(r_j, w_k, w_w, r_slot, r_syms);

    // cap = 4^k + 1 only matters for k = 2 (17); larger k exceed the window
    assign w_cap = (w_k == WB'(2) && w_nk > WB'(17)) ? 6'd17 : 6'(w_nk);

    swkc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_dstart),
        .i_num   (r_cnt),
        .i_den   (r_lim),
        .o_done  (w_ddone),
        .o_quo   (w_quo)
    );

    logic [39:0] w_mul;
    assign w_mul = {23'd0, r_prod} * {17'd0, w_quo};

    logic w_kok;
    assign w_kok = r_kset[r_n] && (32'(w_k) <= MAX_KMER) && (w_k <= w_w);

    assign s_axis_tready = (r_state == ST_IDLE) && !m_axis_tvalid && !i_cfg_valid;
    assign o_cfg_ready = (r_state == ST_IDLE);
    assign m_axis_tdata = {7'd0, r_cplx};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_wsize <= WSIZE_RESET;
            r_kset <= KSET_RESET;
            r_seen <= '0;
            r_slot <= '0;
            r_dstart <= 1'b0;
            m_axis_tvalid <= 1'b0;
        end else begin
            r_dstart <= (r_state == ST_CMP) && (r_j == r_i) && (r_i + WB'(1) == w_nk);
            if (m_axis_tvalid && m_axis_tready && r_state != ST_EMIT) m_axis_tvalid <= 1'b0;
            case (r_state)
                ST_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == CFG_WSIZE) r_wsize <= i_cfg_data[4:0];
                        else r_kset <= i_cfg_data;
                        r_seen <= '0;
                        r_slot <= '0;
                    end else if (s_axis_tvalid && s_axis_tready) begin
                        r_syms[r_slot] <= sym_code(s_axis_tdata);
                        r_slot <= (32'(r_slot) == MAX_WINDOW - 1) ? '0 : r_slot + SB'(1);
                        r_n <= '0;
                        r_prod <= 17'(Q_ONE);
                        r_ovf <= 1'b0;
                        if (r_seen < w_w) begin
                            r_seen <= s_axis_tlast ? '0 : r_seen + WB'(1);
                            if (r_seen + WB'(1) == w_w) begin
                                r_copies <= 6'(w_w >> 1) + 6'd1
                                          + (s_axis_tlast ? 6'(w_w >> 1) : 6'd0);
                                r_state <= ST_KSEL;
                            end
                        end else begin
                            r_copies <= 6'd1 + (s_axis_tlast ? 6'(w_w >> 1) : 6'd0);
                            r_state <= ST_KSEL;
                            if (s_axis_tlast) r_seen <= '0;
                        end
                    end
                end
                ST_KSEL: begin
                    if (32'(r_n) == KSET_BITS) begin
                        r_state <= ST_EMIT;
                    end else if (w_kok) begin
                        r_i <= '0;
                        r_j <= '0;
                        r_dup <= 1'b0;
                        r_cnt <= '0;
                        r_lim <= w_cap;
                        r_state <= ST_CMP;
                    end else begin
                        r_n <= r_n + 4'd1;
                    end
                end
                ST_CMP: begin
                    // compare k-mer i with each earlier one, one pair a cycle
                    if (r_j == r_i) begin
                        if (!r_dup) r_cnt <= r_cnt + 6'd1;
                        r_dup <= 1'b0;
                        r_j <= '0;
                        if (r_i + WB'(1) == w_nk) begin
                            r_state <= ST_DIV;
                        end else begin
                            r_i <= r_i + WB'(1);
                        end
                    end else begin
                        if (w_ci == w_cj) r_dup <= 1'b1;
                        r_j <= r_j + WB'(1);
                    end
                end
                ST_DIV: begin
                    if (w_ddone) r_state <= ST_MUL;
                end
                ST_MUL: begin
                    if (r_ovf || (|w_mul[39:33])) begin
                        r_ovf <= 1'b1;
                        r_prod <= 17'(Q_ONE);
                    end else begin
                        r_prod <= w_mul[32:16];
                    end
                    r_n <= r_n + 4'd1;
                    r_state <= ST_KSEL;
                end
                ST_EMIT: begin
                    if (!m_axis_tvalid || m_axis_tready) begin
                        m_axis_tvalid <= 1'b1;
                        r_cplx <= (r_ovf || r_prod > 17'(Q_ONE)) ? 17'(Q_ONE) : r_prod;
                        m_axis_tlast <= (r_copies == 6'd1);
                        r_copies <= r_copies - 6'd1;
                        if (r_copies == 6'd1) r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    `SWK_ASSERT(a_busy_no_accept, i_clk, i_rst_n, (r_state != ST_IDLE) |-> !s_axis_tready)
    `SWK_ASSERT(a_out_bounded, i_clk, i_rst_n, m_axis_tvalid |-> (m_axis_tdata[16:0] <= 17'd65536))
    `SWK_ASSERT(a_emit_nonzero, i_clk, i_rst_n, (r_state == ST_EMIT) |-> (r_copies != 6'd0))
endmodule
